/* rtl/core/brs_pkg.sv */
// Shared widths, codes, types and constants of the biquadratic root solver.
`timescale 1ns / 1ps

package brs_pkg;

    // Coefficient and root word, signed Q16.16.
    localparam int COEF_W    = 32;
    localparam int FRAC_W    = 16;

    // Shared multiplier: signed operands one bit wider than a coefficient.
    localparam int MUL_W     = COEF_W + 1;
    localparam int PROD_W    = 2 * MUL_W;

    // Discriminant b*b - 4*a*c, exact.
    localparam int D_W       = PROD_W + 1;

    // Divider numerator base (-b +/- sqrt(D)) and denominator (2*a).
    localparam int NB_W      = COEF_W + 3;
    localparam int DEN_W     = COEF_W + 2;
    localparam int DIV_NUM_W = NB_W + FRAC_W;
    localparam int DIV_DEN_W = DEN_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Square root unit.
    localparam int SQ_RAD_W  = PROD_W;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;
    localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

    // Root buffer.
    localparam int MAX_ROOTS = 4;
    localparam int RCNT_W    = $clog2(MAX_ROOTS + 1);
    localparam int RIDX_W    = $clog2(MAX_ROOTS);

    // Running statistics.
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 64;

    // Equation kinds.
    localparam logic [1:0] ACT_LIN  = 2'd0;
    localparam logic [1:0] ACT_QUAD = 2'd1;
    localparam logic [1:0] ACT_BIQ  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_ROOT = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_INF  = 2'd2;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [D_W-1:0]    t_d;
    typedef logic signed [NB_W-1:0]   t_nb;
    typedef logic signed [DEN_W-1:0]  t_den;

    localparam t_coef COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [DIV_NUM_W-1:0] DIV_NEG_LIM =
        {{(DIV_NUM_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};

    // Status of an iterative unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* rtl/core/brs_eq_if.sv */
// Equation input channel: valid, ready and the equation fields.
`timescale 1ns / 1ps

interface brs_eq_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic signed [31:0]   coef_a;
    logic signed [31:0]   coef_b;
    logic signed [31:0]   coef_c;

    modport source (output valid, action, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, action, coef_a, coef_b, coef_c, output ready);
endinterface

/* rtl/core/brs_res_if.sv */
// Result output channel: valid, ready and the fields of one result beat.
`timescale 1ns / 1ps

interface brs_res_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   root;
    logic [1:0]           status;
    logic                 last;
    logic [15:0]          no_root_total;
    logic                 any_root_seen;
    logic [31:0]          least_abs_root;
    logic [63:0]          square_sum;

    modport source (output valid, root, status, last, no_root_total, any_root_seen,
                    least_abs_root, square_sum, input ready);
    modport sink   (input valid, root, status, last, no_root_total, any_root_seen,
                    least_abs_root, square_sum, output ready);
endinterface

/* rtl/core/brs_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module brs_mul (
    input  logic           i_clk,
    input  brs_pkg::t_mul  i_x,
    input  brs_pkg::t_mul  i_y,
    output brs_pkg::t_prod o_prod
);

    brs_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_y;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/brs_div.sv */
// Restoring divider on magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module brs_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [brs_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [brs_pkg::DIV_DEN_W-1:0]   i_den,
    output brs_pkg::t_unit_stat             o_stat,
    output logic [brs_pkg::DIV_NUM_W-1:0]   o_quo
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [brs_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [brs_pkg::DIV_DEN_W-1:0]   r_rem, n_rem;
    logic [brs_pkg::DIV_DEN_W-1:0]   r_den, n_den;
    logic [brs_pkg::DIV_NUM_W-1:0]   r_quo, n_quo;
    logic [brs_pkg::DIV_DEN_W:0]     rem_sh;
    logic [brs_pkg::DIV_DEN_W:0]     rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[brs_pkg::DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            // The dividend shifts out of the top while quotient bits enter below.
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sub[brs_pkg::DIV_DEN_W-1:0];
                n_quo = {r_quo[brs_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[brs_pkg::DIV_DEN_W-1:0];
                n_quo = {r_quo[brs_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == brs_pkg::DIV_CNT_W'(brs_pkg::DIV_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

/* rtl/core/brs_sqrt.sv */
// Restoring integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module brs_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [brs_pkg::SQ_RAD_W-1:0]    i_rad,
    output brs_pkg::t_unit_stat             o_stat,
    output logic [brs_pkg::SQ_ROOT_W-1:0]   o_root
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [brs_pkg::SQ_CNT_W-1:0]    r_cnt, n_cnt;
    logic [brs_pkg::SQ_RAD_W-1:0]    r_rad, n_rad;
    logic [brs_pkg::SQ_REM_W-1:0]    r_rem, n_rem;
    logic [brs_pkg::SQ_ROOT_W-1:0]   r_root, n_root;
    logic [brs_pkg::SQ_REM_W+1:0]    rem_sh;
    logic [brs_pkg::SQ_REM_W+1:0]    trial;
    logic [brs_pkg::SQ_REM_W+1:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_rad[brs_pkg::SQ_RAD_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        rem_sub = rem_sh - trial;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            // Two radicand bits per step against the trial value 4*root+1.
            n_rad = {r_rad[brs_pkg::SQ_RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sub[brs_pkg::SQ_REM_W-1:0];
                n_root = {r_root[brs_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[brs_pkg::SQ_REM_W-1:0];
                n_root = {r_root[brs_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == brs_pkg::SQ_CNT_W'(brs_pkg::SQ_ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

/* rtl/core/biquadratic_root_solver_core.sv */
// Top level of the biquadratic root solver: sequencer, root buffer and statistics.
`timescale 1ns / 1ps
//
//  Channel  Dir  Beat contents
//  -------  ---  -----------------------------------------------------------------
//  i_eq     in   action, coef_a, coef_b, coef_c (signed Q16.16)
//  o_res    out  root, status, last, no_root_total, any_root_seen, least_abs_root,
//                square_sum
//
//  One equation is solved at a time; i_eq.ready is high only while the sequencer
//  is idle. Divisions and square roots run on iterative units, and each emitted
//  root is squared on the shared multiplier before its beat goes out.
//  Reset is synchronous and active low; it clears the sequencer and the running
//  statistics. The result beat sits in an output register, so a new equation is
//  taken while the last beat of the previous one still waits for o_res.ready.

module biquadratic_root_solver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brs_eq_if.sink      i_eq,
    brs_res_if.source   o_res
);

    // Sequencer states, one-hot.
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SETUP  = 14'b00000000000010,
        S_MBB    = 14'b00000000000100,
        S_MAC    = 14'b00000000001000,
        S_DISC   = 14'b00000000010000,
        S_DCHK   = 14'b00000000100000,
        S_SQRT_D = 14'b00000001000000,
        S_DSTART = 14'b00000010000000,
        S_DIV    = 14'b00000100000000,
        S_TCHK   = 14'b00001000000000,
        S_SQRT_T = 14'b00010000000000,
        S_RESULT = 14'b00100000000000,
        S_SQ     = 14'b01000000000000,
        S_EMIT   = 14'b10000000000000
    } t_state;

    t_state                          r_state, n_state;

    // Captured equation.
    logic [1:0]                      r_act, n_act;
    brs_pkg::t_coef                  r_a, n_a;
    brs_pkg::t_coef                  r_b, n_b;
    brs_pkg::t_coef                  r_c, n_c;

    // Solve progress.
    logic                            r_inf, n_inf;
    logic                            r_two, n_two;
    logic                            r_di, n_di;
    brs_pkg::t_nb                    r_nb, n_nb;
    brs_pkg::t_den                   r_den, n_den;
    logic [brs_pkg::SQ_ROOT_W-1:0]   r_s, n_s;
    brs_pkg::t_coef                  r_tq, n_tq;
    brs_pkg::t_prod                  r_bb, n_bb;
    brs_pkg::t_d                     r_d, n_d;

    // Root buffer.
    brs_pkg::t_coef                  r_roots [brs_pkg::MAX_ROOTS];
    brs_pkg::t_coef                  n_roots [brs_pkg::MAX_ROOTS];
    logic [brs_pkg::RCNT_W-1:0]      r_n, n_n;
    logic [brs_pkg::RIDX_W-1:0]      r_ei, n_ei;

    // Running statistics.
    logic [brs_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                            r_seen, n_seen;
    logic [brs_pkg::COEF_W-1:0]      r_least, n_least;
    logic [brs_pkg::SUM_W-1:0]       r_sum, n_sum;

    // Output register.
    logic                            r_ov, n_ov;
    brs_pkg::t_coef                  r_o_root, n_o_root;
    logic [1:0]                      r_o_status, n_o_status;
    logic                            r_o_last, n_o_last;
    logic                            out_load;
    logic                            out_free;
    logic                            in_fire;

    // Shared units.
    brs_pkg::t_mul                   mul_x, mul_y;
    brs_pkg::t_prod                  mul_prod;
    logic                            div_start;
    logic [brs_pkg::DIV_NUM_W-1:0]   div_num;
    logic [brs_pkg::DIV_DEN_W-1:0]   div_den;
    logic [brs_pkg::DIV_NUM_W-1:0]   div_quo;
    brs_pkg::t_unit_stat             div_st;
    logic                            sq_start;
    logic [brs_pkg::SQ_RAD_W-1:0]    sq_rad;
    logic [brs_pkg::SQ_ROOT_W-1:0]   sq_root;
    brs_pkg::t_unit_stat             sq_st;

    // Datapath helpers.
    logic [brs_pkg::NB_W-1:0]        nb_mag;
    logic [brs_pkg::DEN_W-1:0]       den_mag;
    logic                            div_neg;
    brs_pkg::t_coef                  q_sat;
    brs_pkg::t_coef                  cur_root;
    logic [brs_pkg::COEF_W-1:0]      cur_mag;
    brs_pkg::t_coef                  m_val;
    logic [brs_pkg::SUM_W:0]         sum_ext;
    logic                            is_last;
    logic                            go_next;

    brs_mul u_mul (
        .i_clk  (i_clk),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_prod (mul_prod)
    );

    brs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_st),
        .o_quo   (div_quo)
    );

    brs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_stat  (sq_st),
        .o_root  (sq_root)
    );

    assign in_fire  = i_eq.valid && i_eq.ready;
    assign out_free = !r_ov || o_res.ready;

    // The divider works on magnitudes; the sign is restored on its quotient,
    // which then saturates to the Q16.16 range.
    always_comb begin
        nb_mag  = r_nb[brs_pkg::NB_W-1] ? -r_nb : r_nb;
        den_mag = r_den[brs_pkg::DEN_W-1] ? -r_den : r_den;
        div_num = {nb_mag, {brs_pkg::FRAC_W{1'b0}}};
        div_den = den_mag[brs_pkg::DIV_DEN_W-1:0];
        div_neg = r_nb[brs_pkg::NB_W-1] ^ r_den[brs_pkg::DEN_W-1];
        if (!div_neg) begin
            q_sat = (|div_quo[brs_pkg::DIV_NUM_W-1:brs_pkg::COEF_W-1]) ?
                    brs_pkg::COEF_MAX : brs_pkg::t_coef'(div_quo[brs_pkg::COEF_W-1:0]);
        end else begin
            q_sat = (div_quo > brs_pkg::DIV_NEG_LIM) ?
                    brs_pkg::COEF_MIN : -brs_pkg::t_coef'(div_quo[brs_pkg::COEF_W-1:0]);
        end
    end

    always_comb begin
        cur_root = r_roots[r_ei];
        cur_mag  = cur_root[brs_pkg::COEF_W-1] ? -cur_root : cur_root;
        m_val    = brs_pkg::t_coef'({1'b0, sq_root[brs_pkg::COEF_W-2:0]});
        sum_ext  = {1'b0, r_sum} + {1'b0, mul_prod[brs_pkg::SUM_W-1:0]};
        is_last  = ({1'b0, r_ei} == (r_n - 1'b1));
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_inf      = r_inf;
        n_two      = r_two;
        n_di       = r_di;
        n_nb       = r_nb;
        n_den      = r_den;
        n_s        = r_s;
        n_tq       = r_tq;
        n_bb       = r_bb;
        n_d        = r_d;
        n_roots    = r_roots;
        n_n        = r_n;
        n_ei       = r_ei;
        n_cnt      = r_cnt;
        n_seen     = r_seen;
        n_least    = r_least;
        n_sum      = r_sum;
        n_o_root   = r_o_root;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        out_load   = 1'b0;
        mul_x      = '0;
        mul_y      = '0;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        sq_rad     = '0;
        go_next    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_act   = i_eq.action;
                    n_a     = i_eq.coef_a;
                    n_b     = i_eq.coef_b;
                    n_c     = i_eq.coef_c;
                    n_inf   = 1'b0;
                    n_two   = 1'b0;
                    n_di    = 1'b0;
                    n_n     = '0;
                    n_ei    = '0;
                    // The unused kind causes no result and no state change.
                    if (i_eq.action != brs_pkg::ACT_NONE) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                case (r_act)
                    brs_pkg::ACT_LIN: begin
                        if (r_a == '0) begin
                            n_inf   = (r_b == '0);
                            n_state = S_RESULT;
                        end else begin
                            n_nb    = -brs_pkg::t_nb'(r_b);
                            n_den   = brs_pkg::t_den'(r_a);
                            n_state = S_DSTART;
                        end
                    end
                    brs_pkg::ACT_QUAD, brs_pkg::ACT_BIQ: begin
                        // A zero leading coefficient drops to the linear b*x+c.
                        if (r_a != '0) begin
                            n_state = S_MBB;
                        end else if (r_b == '0) begin
                            n_inf   = (r_c == '0);
                            n_state = S_RESULT;
                        end else begin
                            n_nb    = -brs_pkg::t_nb'(r_c);
                            n_den   = brs_pkg::t_den'(r_b);
                            n_state = S_DSTART;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MBB: begin
                mul_x   = brs_pkg::t_mul'(r_b);
                mul_y   = brs_pkg::t_mul'(r_b);
                n_state = S_MAC;
            end
            S_MAC: begin
                mul_x   = brs_pkg::t_mul'(r_a);
                mul_y   = brs_pkg::t_mul'(r_c);
                n_bb    = mul_prod;
                n_state = S_DISC;
            end
            S_DISC: begin
                n_d     = brs_pkg::t_d'(r_bb) - (brs_pkg::t_d'(mul_prod) <<< 2);
                n_state = S_DCHK;
            end
            S_DCHK: begin
                n_den = brs_pkg::t_den'(r_a) <<< 1;
                if (r_d[brs_pkg::D_W-1]) begin
                    n_state = S_RESULT;
                end else if (r_d == '0) begin
                    n_nb    = -brs_pkg::t_nb'(r_b);
                    n_state = S_DSTART;
                end else begin
                    sq_start = 1'b1;
                    sq_rad   = r_d[brs_pkg::SQ_RAD_W-1:0];
                    n_two    = 1'b1;
                    n_state  = S_SQRT_D;
                end
            end
            S_SQRT_D: begin
                if (sq_st.done) begin
                    n_s     = sq_root;
                    n_nb    = -brs_pkg::t_nb'(r_b) - brs_pkg::t_nb'({2'b00, sq_root});
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_st.done) begin
                    n_tq    = q_sat;
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                if (r_act != brs_pkg::ACT_BIQ) begin
                    n_roots[r_n[brs_pkg::RIDX_W-1:0]] = r_tq;
                    n_n     = r_n + 1'b1;
                    go_next = 1'b1;
                end else if (!r_tq[brs_pkg::COEF_W-1] && (r_tq != '0)) begin
                    // Positive t: x = -/+ sqrt(t) taken on t*2^16.
                    sq_start = 1'b1;
                    sq_rad   = {{(brs_pkg::SQ_RAD_W-brs_pkg::COEF_W-brs_pkg::FRAC_W+1){1'b0}},
                                r_tq[brs_pkg::COEF_W-2:0], {brs_pkg::FRAC_W{1'b0}}};
                    n_state  = S_SQRT_T;
                end else if (r_tq == '0) begin
                    n_roots[r_n[brs_pkg::RIDX_W-1:0]] = '0;
                    n_n     = r_n + 1'b1;
                    go_next = 1'b1;
                end else begin
                    go_next = 1'b1;
                end
            end
            S_SQRT_T: begin
                if (sq_st.done) begin
                    n_roots[r_n[brs_pkg::RIDX_W-1:0]]        = -m_val;
                    n_roots[r_n[brs_pkg::RIDX_W-1:0] + 1'b1] = m_val;
                    n_n     = r_n + 2'd2;
                    go_next = 1'b1;
                end
            end
            S_RESULT: begin
                if (r_inf || (r_n == '0)) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        n_o_root   = '0;
                        n_o_last   = 1'b1;
                        n_state    = S_IDLE;
                        if (r_inf) begin
                            n_o_status = brs_pkg::ST_INF;
                        end else begin
                            n_o_status = brs_pkg::ST_NONE;
                            n_cnt      = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
                        end
                    end
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                mul_x   = brs_pkg::t_mul'({1'b0, cur_mag});
                mul_y   = brs_pkg::t_mul'({1'b0, cur_mag});
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Operands stay put so the product holds while the beat waits.
                mul_x = brs_pkg::t_mul'({1'b0, cur_mag});
                mul_y = brs_pkg::t_mul'({1'b0, cur_mag});
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_root   = cur_root;
                    n_o_status = brs_pkg::ST_ROOT;
                    n_o_last   = is_last;
                    n_sum      = sum_ext[brs_pkg::SUM_W] ? '1 : sum_ext[brs_pkg::SUM_W-1:0];
                    n_seen     = 1'b1;
                    if (!r_seen || (cur_mag < r_least)) begin
                        n_least = cur_mag;
                    end
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ei    = r_ei + 1'b1;
                        n_state = S_SQ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // After a quotient is handled: the second root of a two-root quadratic
        // uses -b + sqrt(D), otherwise the buffered roots go out.
        if (go_next) begin
            if (r_two && !r_di) begin
                n_di    = 1'b1;
                n_nb    = -brs_pkg::t_nb'(r_b) + brs_pkg::t_nb'({2'b00, r_s});
                n_state = S_DSTART;
            end else begin
                n_state = S_RESULT;
            end
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (out_load) begin
            n_ov = 1'b1;
        end else if (o_res.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inf   <= 1'b0;
            r_two   <= 1'b0;
            r_di    <= 1'b0;
            r_n     <= '0;
            r_ei    <= '0;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
            r_least <= '0;
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inf   <= n_inf;
            r_two   <= n_two;
            r_di    <= n_di;
            r_n     <= n_n;
            r_ei    <= n_ei;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
            r_least <= n_least;
            r_sum   <= n_sum;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_nb       <= n_nb;
        r_den      <= n_den;
        r_s        <= n_s;
        r_tq       <= n_tq;
        r_bb       <= n_bb;
        r_d        <= n_d;
        r_roots    <= n_roots;
        r_o_root   <= n_o_root;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign i_eq.ready           = (r_state == S_IDLE);
    assign o_res.valid          = r_ov;
    assign o_res.root           = r_o_root;
    assign o_res.status         = r_o_status;
    assign o_res.last           = r_o_last;
    assign o_res.no_root_total  = r_cnt;
    assign o_res.any_root_seen  = r_seen;
    assign o_res.least_abs_root = r_least;
    assign o_res.square_sum     = r_sum;

    // A quotient only arrives while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_sqrt_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_st.done |-> ((r_state == S_SQRT_D) || (r_state == S_SQRT_T)))
        else $error("square root finished outside its wait state");

    a_div_wait_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (div_st.busy || div_st.done))
        else $error("waiting on an idle divider");

    a_root_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n <= brs_pkg::RCNT_W'(brs_pkg::MAX_ROOTS)))
        else $error("root buffer overfilled");

    a_status_beat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != brs_pkg::ST_ROOT)) |->
        (o_res.last && (o_res.root == '0)))
        else $error("status beat is not a lone zero beat");

endmodule

/* bench/brs_root_checker.sv */
// Checker of the root solver: predicts result beats from accepted equations and compares them.
`timescale 1ns / 1ps

module brs_root_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brs_eq_if           eq,
    brs_res_if          res,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic signed [31:0] root;
        logic [1:0]         status;
        logic               last;
        logic [15:0]        no_root_total;
        logic               any_root_seen;
        logic [31:0]        least_abs_root;
        logic [63:0]        square_sum;
    } t_root_beat;

    t_root_beat         root_beats_due[$];
    logic [15:0]        rootless_cnt;
    logic               seen_root;
    logic [31:0]        least_mag;
    logic [63:0]        squares_acc;
    int                 fail_cnt;
    int                 pending_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // Truncating divide, then clamp to the signed Q16.16 range.
    function automatic longint sat_quotient(longint num, longint den);
        longint unsigned q;
        logic            neg;
        q   = magnitude(num) / magnitude(den);
        neg = (num < 0) != (den < 0);
        if (!neg)
            return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
        return (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= acc + bitv) begin
                x   = x - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    function automatic int linear_roots(longint a, longint b, output longint r0,
                                        output logic every_x);
        every_x = 1'b0;
        r0      = 0;
        if (a == 0) begin
            every_x = (b == 0);
            return 0;
        end
        r0 = sat_quotient(-b * 65536, a);
        return 1;
    endfunction

    function automatic int quadratic_roots(longint a, longint b, longint c,
                                           output longint r0, output longint r1,
                                           output logic every_x);
        longint unsigned b2, hq, dq, q, rem, s, rlo;
        longint          p;
        int              sgn;
        r1 = 0;
        if (a == 0)
            return linear_roots(b, c, r0, every_x);
        every_x = 1'b0;
        r0  = 0;
        p   = a * c;
        b2  = b * b;
        hq  = b2 >> 2;
        rlo = b2 & 64'd3;
        if (p <= 0) begin
            dq  = hq + magnitude(p);
            sgn = (b2 == 0 && p == 0) ? 0 : 1;
        end else if (hq > p || (hq == p && rlo != 0)) begin
            dq  = hq - p;
            sgn = 1;
        end else begin
            dq  = 0;
            sgn = (hq == p) ? 0 : -1;
        end
        if (sgn < 0)
            return 0;
        if (sgn == 0) begin
            r0 = sat_quotient(-b * 65536, 2 * a);
            return 1;
        end
        q   = floor_sqrt(dq);
        rem = dq - q * q;
        s   = 2 * q + ((rem * 4 + rlo >= 4 * q + 1) ? 1 : 0);
        r0  = sat_quotient((-b - longint'(s)) * 65536, 2 * a);
        r1  = sat_quotient((-b + longint'(s)) * 65536, 2 * a);
        return 2;
    endfunction

    function automatic void push_beat(longint root, logic [1:0] status, logic last);
        t_root_beat e;
        e.root           = root[31:0];
        e.status         = status;
        e.last           = last;
        e.no_root_total  = rootless_cnt;
        e.any_root_seen  = seen_root;
        e.least_abs_root = least_mag;
        e.square_sum     = squares_acc;
        root_beats_due   = {root_beats_due, e};
    endfunction

    // Works out every result beat of one equation and updates the statistics.
    function automatic void solve_equation(logic [1:0] kind, longint a, longint b,
                                           longint c);
        longint          roots[4];
        longint          t0, t1, tv, m;
        longint unsigned mg, sq;
        logic            every_x;
        int              n, nt;
        n = 0;
        every_x = 1'b0;
        case (kind)
            brs_pkg::ACT_LIN:  n = linear_roots(a, b, roots[0], every_x);
            brs_pkg::ACT_QUAD: n = quadratic_roots(a, b, c, roots[0], roots[1], every_x);
            brs_pkg::ACT_BIQ: begin
                nt = quadratic_roots(a, b, c, t0, t1, every_x);
                for (int i = 0; i < nt && !every_x; i++) begin
                    tv = (i == 0) ? t0 : t1;
                    if (tv > 0) begin
                        m = floor_sqrt(longint'(tv) << 16);
                        roots[n]     = -m;
                        roots[n + 1] = m;
                        n = n + 2;
                    end else if (tv == 0) begin
                        roots[n] = 0;
                        n = n + 1;
                    end
                end
            end
            default: return;
        endcase
        if (every_x) begin
            push_beat(0, brs_pkg::ST_INF, 1'b1);
            return;
        end
        if (n == 0) begin
            if (rootless_cnt != 16'hFFFF)
                rootless_cnt = rootless_cnt + 16'd1;
            push_beat(0, brs_pkg::ST_NONE, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            mg = magnitude(roots[i]);
            sq = mg * mg;
            squares_acc = (squares_acc > ~64'd0 - sq) ? ~64'd0 : squares_acc + sq;
            if (!seen_root || mg < least_mag) begin
                least_mag = mg[31:0];
                seen_root = 1'b1;
            end
            push_beat(roots[i], brs_pkg::ST_ROOT, i == n - 1);
        end
    endfunction

    always @(posedge i_clk) begin
        t_root_beat e;
        if (!i_rst_n) begin
            rootless_cnt = '0;
            seen_root    = 1'b0;
            least_mag    = '0;
            squares_acc  = '0;
            fail_cnt     = 0;
            root_beats_due.delete();
        end else begin
            if (res.valid && res.ready) begin
                if (root_beats_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result beat: root %h status %0d",
                                 res.root, res.status);
                end else begin
                    e = root_beats_due.pop_front();
                    if (res.root !== e.root || res.status !== e.status ||
                        res.last !== e.last || res.no_root_total !== e.no_root_total ||
                        res.any_root_seen !== e.any_root_seen ||
                        res.least_abs_root !== e.least_abs_root ||
                        res.square_sum !== e.square_sum) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch: exp root %h st %0d last %b nr %0d seen %b ",
                                      "least %h sum %h / got root %h st %0d last %b nr %0d ",
                                      "seen %b least %h sum %h"},
                                     e.root, e.status, e.last, e.no_root_total,
                                     e.any_root_seen, e.least_abs_root, e.square_sum,
                                     res.root, res.status, res.last, res.no_root_total,
                                     res.any_root_seen, res.least_abs_root, res.square_sum);
                    end
                end
            end
            if (eq.valid && eq.ready)
                solve_equation(eq.action, longint'(eq.coef_a), longint'(eq.coef_b),
                               longint'(eq.coef_c));
        end
        pending_cnt = root_beats_due.size();
    end

endmodule

/* bench/biquadratic_root_solver_core_tb.sv */
// Top of the root solver testbench: clock, reset, equation stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module biquadratic_root_solver_core_tb;

    // The run is bounded well above the slowest legal run: about 130 equations, each
    // with up to four result beats behind receiver stalls, sender gaps and one long
    // deliberate hold-off.
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_EQS  = 107;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;

    brs_eq_if  eq_ch();
    brs_res_if res_ch();

    biquadratic_root_solver_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eq    (eq_ch),
        .o_res   (res_ch)
    );

    brs_root_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .eq           (eq_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver. It starts with its own stall pattern, then holds ready low for a long
    // stretch so the output register fills and the block stops taking equations, and
    // then returns to the pattern for good. The pattern switches between always-ready
    // runs, sparse acceptance, short full stalls and coin-flip ready.
    initial begin
        int mode;
        int span;
        int elapsed;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        elapsed = 0;
        forever begin
            if (elapsed >= 3000 && elapsed < 3000 + HOLD_CYCLES) begin
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    res_ch.ready <= 1'b0;
                end
                elapsed += HOLD_CYCLES;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 120);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    2:       res_ch.ready <= 1'b0;
                    default: res_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
            elapsed += span;
        end
    end

    // Burst bookkeeping for the sender: when a burst runs out, valid drops for a
    // random gap; inside a burst the next equation follows with valid kept high.
    int burst_left;

    task automatic send_eq(input logic [1:0] kind, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c);
        if (burst_left == 0) begin
            eq_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        eq_ch.valid  <= 1'b1;
        eq_ch.action <= kind;
        eq_ch.coef_a <= a;
        eq_ch.coef_b <= b;
        eq_ch.coef_c <= c;
        do @(posedge i_clk); while (!eq_ch.ready);
        burst_left--;
    endtask

    // One coefficient: full random words, small values between -32 and +32, zero or an
    // extreme, so every bit toggles yet most equations stay well conditioned.
    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 32'd0;
            3:       return $urandom_range(0, 1) ? brs_pkg::COEF_MAX : brs_pkg::COEF_MIN;
            default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    initial begin
        logic [1:0]  kind;
        logic [31:0] a, b, c;
        eq_ch.valid  <= 1'b0;
        eq_ch.action <= brs_pkg::ACT_LIN;
        eq_ch.coef_a <= '0;
        eq_ch.coef_b <= '0;
        eq_ch.coef_c <= '0;
        i_rst_n      <= 1'b0;
        burst_left   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed equations. Linear: every x a root, no root, plain, saturating.
        send_eq(brs_pkg::ACT_LIN,  32'd0,         32'd0,         32'd0);
        send_eq(brs_pkg::ACT_LIN,  32'd0,         32'h0001_0000, 32'd0);
        send_eq(brs_pkg::ACT_LIN,  32'h0002_0000, 32'hFFFA_0000, 32'd5);
        send_eq(brs_pkg::ACT_LIN,  32'd1,         brs_pkg::COEF_MIN, 32'd0);
        send_eq(brs_pkg::ACT_LIN,  32'hFFFF_FFFF, brs_pkg::COEF_MAX, 32'd0);
        send_eq(brs_pkg::ACT_LIN,  brs_pkg::COEF_MIN, brs_pkg::COEF_MIN,
                brs_pkg::COEF_MAX);
        // Quadratic: negative, zero and positive discriminant, and the fall-back
        // to a linear equation when the leading coefficient is zero.
        send_eq(brs_pkg::ACT_QUAD, 32'h0001_0000, 32'd0,         32'h0001_0000);
        send_eq(brs_pkg::ACT_QUAD, 32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        send_eq(brs_pkg::ACT_QUAD, 32'h0001_0000, 32'd0,         32'hFFFC_0000);
        send_eq(brs_pkg::ACT_QUAD, 32'd0,         32'h0002_0000, 32'h0004_0000);
        send_eq(brs_pkg::ACT_QUAD, 32'd0,         32'd0,         32'd0);
        send_eq(brs_pkg::ACT_QUAD, 32'd0,         32'd0,         32'h0003_0000);
        send_eq(brs_pkg::ACT_QUAD, brs_pkg::COEF_MIN, brs_pkg::COEF_MAX,
                brs_pkg::COEF_MAX);
        send_eq(brs_pkg::ACT_QUAD, 32'd1,         brs_pkg::COEF_MIN, brs_pkg::COEF_MIN);
        // Biquadratic: four roots, t of zero, negative t, fall-back and degenerate.
        send_eq(brs_pkg::ACT_BIQ,  32'h0001_0000, 32'hFFFB_0000, 32'h0004_0000);
        send_eq(brs_pkg::ACT_BIQ,  32'h0001_0000, 32'hFFFF_0000, 32'd0);
        send_eq(brs_pkg::ACT_BIQ,  32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
        send_eq(brs_pkg::ACT_BIQ,  32'd0,         32'h0001_0000, 32'hFFF7_0000);
        send_eq(brs_pkg::ACT_BIQ,  32'd0,         32'h0001_0000, 32'd0);
        send_eq(brs_pkg::ACT_BIQ,  32'd0,         32'd0,         32'd0);
        send_eq(brs_pkg::ACT_BIQ,  32'd0,         32'd0,         32'h0001_0000);
        send_eq(brs_pkg::ACT_BIQ,  32'd1,         brs_pkg::COEF_MIN, brs_pkg::COEF_MAX);
        // The unused kind produces nothing at all.
        send_eq(brs_pkg::ACT_NONE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);

        // Random equations, mostly the three real kinds.
        for (int n = 0; n < RANDOM_EQS; n++) begin
            if (n == RANDOM_EQS / 2) begin
                // Let the block drain completely before carrying on.
                eq_ch.valid <= 1'b0;
                burst_left = 0;
                do @(posedge i_clk); while (pending != 0);
            end
            kind = ($urandom_range(0, 19) == 0) ? brs_pkg::ACT_NONE :
                   2'($urandom_range(0, 2));
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            // Half the time force a and c apart in sign so real roots are common.
            if ($urandom_range(0, 1) && a != 0 && c[31] == a[31])
                c = -c;
            send_eq(kind, a, b, c);
        end
        eq_ch.valid <= 1'b0;

        // Wait for every expected beat, then watch for stray extra beats.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
